@@ rtl/mlfd_pkg.sv @@
// Shared types and constants for the MAC learning forward decider.
// No dependencies; imported by every module of the block.
package mlfd_pkg;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_ARP    = 16'h0806;
  localparam logic [15:0] ETH_IPV6   = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] FLOOD_PORT = 16'd65531;
  localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0]  UNK_PROTO_RST = 8'hFF;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_FLOOD = 2'd1;
  localparam logic [1:0] ACT_ADD   = 2'd2;

  localparam int IN_W  = 184;
  localparam int OUT_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SRC_SCAN,
    ST_LEARN,
    ST_DST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0] in_port;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] ether_type;
    logic [7:0]  ip_proto;
    logic [15:0] arp_opcode;
    logic [15:0] l4_src_port;
    logic [15:0] l4_dst_port;
  } hdr_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] fwd_port;
    logic        dst_found;
    logic [7:0]  match_proto;
    logic [15:0] match_l4_src;
    logic [15:0] match_l4_dst;
    logic        host_learned;
    logic        table_full;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch header, clear per-item flags
    logic scan_start; // reset scan pointer, latch key
    logic key_dst;    // key select for scan_start: 1 = dst_mac
    logic scan_run;   // advance scan one step
    logic learn;      // store src_mac/in_port if room
    logic out_load;   // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic scan_hit;
    logic is_arp;
    logic dst_bcast;
    logic need_dst;   // IPv4 ICMP/TCP/UDP lookup
  } stat_t;

endpackage

@@ rtl/mlfd_ctrl.sv @@
// Controller FSM for the MAC learning forward decider.
// Depends on mlfd_pkg; drives cmd_t to mlfd_datapath, owns output valid.
module mlfd_ctrl
  import mlfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.is_arp)        state_nxt = ST_SRC_SCAN;
        else if (stat.need_dst) state_nxt = ST_DST_SCAN;
        else                    state_nxt = ST_FINISH;
      end
      ST_SRC_SCAN: begin
        if (stat.scan_done) state_nxt = ST_LEARN;
      end
      ST_LEARN: begin
        state_nxt = stat.dst_bcast ? ST_FINISH : ST_DST_SCAN;
      end
      ST_DST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_tvalid;
      end
      ST_DECODE: begin
        cmd.scan_start = stat.is_arp || stat.need_dst;
        cmd.key_dst    = !stat.is_arp;
      end
      ST_SRC_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.learn    = stat.scan_done && !stat.scan_hit;
      end
      ST_LEARN: begin
        cmd.scan_start = !stat.dst_bcast;
        cmd.key_dst    = 1'b1;
      end
      ST_DST_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = slot_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/mlfd_datapath.sv @@
// Datapath: header latch, host table memory, linear scan, result register.
// Depends on mlfd_pkg; commanded by mlfd_ctrl.
module mlfd_datapath
  import mlfd_pkg::*;
#(
  parameter int HOST_TABLE_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [7:0]                           cfg_wdata,
  input  hdr_t                                 hdr_in,
  input  cmd_t                                 cmd,
  output stat_t                                stat,
  output res_t                                 res,
  output logic [$clog2(HOST_TABLE_DEPTH):0]    host_count
);

  localparam int AW = $clog2(HOST_TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(HOST_TABLE_DEPTH);

  // entry = {port, mac}
  logic [63:0] host_mem [HOST_TABLE_DEPTH];

  logic [7:0]    unk_proto_r;
  hdr_t          hdr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_addr_r;
  logic          issue_r;
  logic [63:0]   rd_data_r;
  logic [47:0]   key_r;
  logic          key_dst_r;
  logic          found_r;
  logic [15:0]   dst_port_r;
  logic          learned_r;
  logic          full_r;
  res_t          res_r, res_nxt;

  logic hit_now, scan_more;
  logic is_ipv4, is_ipv6, is_arp, dst_bcast, l4_proto, is_unk;

  assign is_ipv4   = (hdr_r.ether_type == ETH_IPV4);
  assign is_ipv6   = (hdr_r.ether_type == ETH_IPV6);
  assign is_arp    = (hdr_r.ether_type == ETH_ARP);
  assign dst_bcast = (hdr_r.dst_mac == MAC_BCAST);
  assign l4_proto  = (hdr_r.ip_proto == PROTO_ICMP) || (hdr_r.ip_proto == PROTO_TCP) ||
                     (hdr_r.ip_proto == PROTO_UDP);
  assign is_unk    = (hdr_r.ip_proto == unk_proto_r);

  assign scan_more = (scan_addr_r < count_r);
  assign hit_now   = issue_r && (rd_data_r[47:0] == key_r);

  always_comb begin
    stat.scan_done = hit_now || (!issue_r && !scan_more);
    stat.scan_hit  = hit_now;
    stat.is_arp    = is_arp;
    stat.dst_bcast = dst_bcast;
    stat.need_dst  = is_ipv4 && l4_proto;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unk_proto_r <= UNK_PROTO_RST;
    end else if (cfg_we) begin
      unk_proto_r <= cfg_wdata;
    end
  end

  // host count and per-item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      learned_r <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        learned_r <= 1'b0;
        full_r    <= 1'b0;
      end
      if (cmd.learn) begin
        if (count_r < DEPTH_C) begin
          count_r   <= count_r + 1'b1;
          learned_r <= 1'b1;
        end else begin
          full_r <= 1'b1;
        end
      end
    end
  end

  // memory write
  always_ff @(posedge clk) begin
    if (cmd.learn && (count_r < DEPTH_C)) begin
      host_mem[count_r[AW-1:0]] <= {hdr_r.in_port, hdr_r.src_mac};
    end
  end

  // memory read, one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_run && scan_more) begin
      rd_data_r <= host_mem[scan_addr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      issue_r     <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (cmd.accept) found_r <= 1'b0;
      if (cmd.scan_start) begin
        scan_addr_r <= '0;
        issue_r     <= 1'b0;
      end else if (cmd.scan_run) begin
        issue_r <= scan_more;
        if (scan_more) scan_addr_r <= scan_addr_r + 1'b1;
        if (hit_now && key_dst_r) found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) hdr_r <= hdr_in;
    if (cmd.scan_start) begin
      key_r     <= cmd.key_dst ? hdr_r.dst_mac : hdr_r.src_mac;
      key_dst_r <= cmd.key_dst;
    end
    if (cmd.scan_run && hit_now && key_dst_r) dst_port_r <= rd_data_r[63:48];
  end

  // result formation
  always_comb begin
    res_nxt = '0;
    if (is_ipv6) begin
      res_nxt.action   = ACT_FLOOD;
      res_nxt.fwd_port = FLOOD_PORT;
    end else if (is_arp) begin
      res_nxt.host_learned = learned_r;
      res_nxt.table_full   = full_r;
      if (dst_bcast) begin
        res_nxt.action   = ACT_FLOOD;
        res_nxt.fwd_port = FLOOD_PORT;
      end else begin
        res_nxt.action      = ACT_ADD;
        res_nxt.dst_found   = found_r;
        res_nxt.fwd_port    = found_r ? dst_port_r : 16'd0;
        res_nxt.match_proto = hdr_r.arp_opcode[7:0];
      end
    end else if (is_ipv4) begin
      if (l4_proto) begin
        res_nxt.action      = ACT_ADD;
        res_nxt.dst_found   = found_r;
        res_nxt.fwd_port    = found_r ? dst_port_r : 16'd0;
        res_nxt.match_proto = hdr_r.ip_proto;
        if (hdr_r.ip_proto != PROTO_ICMP) begin
          res_nxt.match_l4_src = hdr_r.l4_src_port;
          res_nxt.match_l4_dst = hdr_r.l4_dst_port;
        end
      end else if (is_unk) begin
        res_nxt.action   = ACT_FLOOD;
        res_nxt.fwd_port = FLOOD_PORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) res_r <= res_nxt;
  end

  assign res        = res_r;
  assign host_count = count_r;

endmodule

@@ rtl/mac_learning_forward_decider.sv @@
// Top level of the MAC learning forward decider.
// Depends on mlfd_pkg, mlfd_ctrl and mlfd_datapath.
//
// Channel   Dir  Handshake           Payload
// in_       in   in_tvalid/tready    in_tdata[183:0]: parsed packet-in header
// out_      out  out_tvalid/tready   out_tdata[63:0]: forwarding decision
// cfg_      in   cfg_we              cfg_wdata[7:0]: unknown_proto_code
//
// Flow: one transaction at a time. A lookup walks the table one entry a cycle
// from index 0, stopping at the first hit. ARP walks it for the source MAC, then
// a learn state, then walks again for the destination MAC unless it is broadcast.
// Reset: synchronous, active low; empties the host table (fill count to zero)
// and sets unknown_proto_code to 255. No clearing pass is needed.
// Stalls: a finished result sits in the output register; the next transaction
// is accepted meanwhile and waits only at its own result load.
module mac_learning_forward_decider
  import mlfd_pkg::*;
#(
  parameter int HOST_TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // in_tdata, low bit up: in_port[15:0], src_mac[63:16], dst_mac[111:64],
  // ether_type[127:112], ip_proto[135:128], arp_opcode[151:136],
  // l4_src_port[167:152], l4_dst_port[183:168]
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,
  // out_tdata, low bit up: action[1:0], fwd_port[17:2], dst_found[18],
  // match_proto[26:19], match_l4_src[42:27], match_l4_dst[58:43],
  // host_learned[59], table_full[60], zero[63:61]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  localparam int CW = $clog2(HOST_TABLE_DEPTH) + 1;

  hdr_t          hdr_in;
  res_t          res;
  cmd_t          cmd;
  stat_t         stat;
  logic [CW-1:0] host_count;

  assign hdr_in.in_port     = in_tdata[15:0];
  assign hdr_in.src_mac     = in_tdata[63:16];
  assign hdr_in.dst_mac     = in_tdata[111:64];
  assign hdr_in.ether_type  = in_tdata[127:112];
  assign hdr_in.ip_proto    = in_tdata[135:128];
  assign hdr_in.arp_opcode  = in_tdata[151:136];
  assign hdr_in.l4_src_port = in_tdata[167:152];
  assign hdr_in.l4_dst_port = in_tdata[183:168];

  assign out_tdata = {3'b000, res.table_full, res.host_learned, res.match_l4_dst,
                      res.match_l4_src, res.match_proto, res.dst_found,
                      res.fwd_port, res.action};

  mlfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mlfd_datapath #(
    .HOST_TABLE_DEPTH (HOST_TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .hdr_in     (hdr_in),
    .cmd        (cmd),
    .stat       (stat),
    .res        (res),
    .host_count (host_count)
  );

  // one transaction in flight: the cycle after an accept is always busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    host_count <= CW'(HOST_TABLE_DEPTH))
    else $error("host count beyond table depth");

  // a result never both learns and reports a full table
  a_learn_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res.host_learned && res.table_full))
    else $error("learned and full together");

  // flood always goes to the flood port
  a_flood_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.action == ACT_FLOOD) |-> (res.fwd_port == FLOOD_PORT))
    else $error("flood with wrong port");

endmodule
